### hdl/resampling_voice_with_gain_ramp_core_macros.svh
// assertion macros shared by the voice core
`ifndef RESAMPLING_VOICE_WITH_GAIN_RAMP_CORE_MACROS_SVH
`define RESAMPLING_VOICE_WITH_GAIN_RAMP_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RVG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rvg_pkg.sv
// shared types and constants of the resampling voice core
package rvg_pkg;

    // fixed field and state widths
    localparam int SMP_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int LEN_W      = 17;
    localparam int PITCH_W    = 18;
    localparam int POS_W      = 20;
    localparam int DIV_W      = 21;
    localparam int CNT_W      = 5;
    localparam int MUL_A_W    = 17;
    localparam int GAIN_SHIFT = 15;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 3;

    // action codes carried in tuser
    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_PRODUCE = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP          = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_START         = 3'd7;

    // shared unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    // what a finished remainder pass feeds
    typedef enum logic [1:0] {
        REM_POS,
        REM_WORD,
        REM_ADV
    } rem_kind_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAMP,
        ST_REM,
        ST_NEXTF,
        ST_WORD,
        ST_RD,
        ST_CAP,
        ST_ISUB,
        ST_IMUL,
        ST_IBIAS,
        ST_IADD,
        ST_GMUL,
        ST_GBIAS,
        ST_ADV1,
        ST_ADV2,
        ST_FINISH
    } state_t;

endpackage

### hdl/rvg_alu.sv
// shared arithmetic unit: one adder/subtractor and one registered multiplier
module rvg_alu #(
    parameter int MUL_B_W = 17,
    localparam int W = rvg_pkg::MUL_A_W + MUL_B_W
) (
    input  logic                   clk,
    input  rvg_pkg::alu_op_t       op,
    input  logic signed [W-1:0]    opnd_a,
    input  logic signed [W-1:0]    opnd_b,
    output logic signed [W-1:0]    sum,
    output logic signed [W-1:0]    prod
);

    logic signed [W-1:0] prod_reg;

    // add or subtract, combinational
    assign sum = (op == rvg_pkg::ALU_SUB) ? (opnd_a - opnd_b) : (opnd_a + opnd_b);

    // multiply, result held for the following step
    always_ff @(posedge clk)
    begin
        if (op == rvg_pkg::ALU_MUL)
        begin
            prod_reg <= $signed(opnd_a[rvg_pkg::MUL_A_W-1:0]) * $signed(opnd_b[MUL_B_W-1:0]);
        end
    end

    assign prod = prod_reg;

endmodule

### hdl/rvg_store.sv
// sample store: one write port, one registered read port
module rvg_store #(
    parameter int WORDS = 65536,
    localparam int AW = $clog2(WORDS)
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [rvg_pkg::SMP_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [rvg_pkg::SMP_W-1:0] rd_data
);

    logic signed [rvg_pkg::SMP_W-1:0] mem [WORDS];
    logic signed [rvg_pkg::SMP_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/resampling_voice_with_gain_ramp_core.sv
// top level of the resampling voice: sequencer, voice state and stream ports
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser: action; tdata: address, value, mix l, mix r
//  m_*       out  m_tvalid/m_tready    tdata: out l, out r, is_playing
//  cfg_*     in   cfg_we               cfg_index, cfg_data
//
//  write, restart and unknown actions leave the block idle; a produce on a stopped voice
//  goes straight to the output load; one on an active voice runs: ramp, 4 store reads of
//  word, read and capture steps, 6 steps per channel through the shared adder/multiplier,
//  2 advance steps, output load; a shared-subtractor remainder pass is added for position
//  past the length, word index past a store whose size is not a power of two, loop wrap
//  past the length; no clearing pass after reset; a held result stalls only the output load
`include "resampling_voice_with_gain_ramp_core_macros.svh"
module resampling_voice_with_gain_ramp_core #(
    parameter int STORE_WORDS    = 65536,
    parameter int FRACTION_WIDTH = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,  // store_address, store_value, mix_left, mix_right
    input  logic [1:0]                        s_tuser,  // action
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,  // out_left, out_right, is_playing, zero pad
    // configuration writes
    input  logic                              cfg_we,
    input  logic [rvg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rvg_pkg::CFG_W-1:0]         cfg_data
);

    localparam int  AW         = $clog2(STORE_WORDS);
    localparam int  AXW        = (AW > 16) ? AW : 16;
    localparam int  FW         = FRACTION_WIDTH;
    localparam int  MB         = ((FW > 16) ? FW : 16) + 1;
    localparam int  AL_W       = rvg_pkg::MUL_A_W + MB;
    localparam int  ACC_W      = ((FW > rvg_pkg::PITCH_W) ? FW : rvg_pkg::PITCH_W) + 1;
    localparam int  CW         = ACC_W - FW;
    localparam bit  STORE_POW2 = (STORE_WORDS & (STORE_WORDS - 1)) == 0;
    localparam logic [rvg_pkg::DIV_W-1:0] STORE_LIM = rvg_pkg::DIV_W'(STORE_WORDS);
    localparam logic [AL_W-1:0] FRAC_BIAS = AL_W'((64'd1 << FW) - 64'd1);
    localparam logic [AL_W-1:0] GAIN_BIAS = AL_W'((64'd1 << rvg_pkg::GAIN_SHIFT) - 64'd1);
    localparam logic signed [18:0] SAT_MAX = 19'sd32767;
    localparam logic signed [18:0] SAT_MIN = -19'sd32768;

    // gain ramp toward target, limited by step
    function automatic logic [15:0] ramp(input logic [15:0] cur, input logic [15:0] tgt,
                                         input logic [15:0] stp);
        logic [15:0] diff;
        if (tgt > cur)
        begin
            diff = tgt - cur;
            return (diff > stp) ? (cur + stp) : tgt;
        end
        diff = cur - tgt;
        return (diff > stp) ? (cur - stp) : tgt;
    endfunction

    // mix plus contribution, saturated to 16 bits
    function automatic logic signed [15:0] sat_mix(input logic signed [15:0] mix,
                                                   input logic signed [17:0] c);
        logic signed [18:0] s;
        s = 19'(mix) + 19'(c);
        if (s > SAT_MAX)
        begin
            return 16'sh7fff;
        end
        if (s < SAT_MIN)
        begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    // input fields
    logic [15:0]        store_address;
    logic signed [15:0] store_value;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic [1:0]         action;
    logic               in_accept;

    // configuration registers
    logic [rvg_pkg::PITCH_W-1:0] pitch_reg;
    logic [15:0]                 tgt_l_reg;
    logic [15:0]                 tgt_r_reg;
    logic [15:0]                 gstep_reg;
    logic [rvg_pkg::LEN_W-1:0]   length_reg;
    logic [1:0]                  chan_reg;
    logic                        loop_reg;
    logic [15:0]                 start_reg;

    // voice state
    rvg_pkg::state_t           state_reg;
    rvg_pkg::state_t           state_next;
    logic [rvg_pkg::POS_W-1:0] pos_reg;
    logic [FW-1:0]             frac_reg;
    logic [15:0]               gain_l_reg;
    logic [15:0]               gain_r_reg;
    logic                      active_reg;

    // sequencer working registers
    logic [rvg_pkg::CNT_W-1:0] cnt_reg;
    logic [1:0]                k_reg;
    logic                      ch_reg;
    logic signed [15:0]        mix_l_reg;
    logic signed [15:0]        mix_r_reg;
    logic [rvg_pkg::LEN_W-1:0] f1_reg;
    logic [17:0]               w1_reg;
    logic [17:0]               w2_reg;
    logic signed [15:0]        smp_a_reg [2];
    logic signed [15:0]        smp_b_reg [2];
    logic signed [16:0]        d_reg;
    logic signed [16:0]        q_reg;
    logic signed [15:0]        v_reg;
    logic signed [17:0]        contrib_l_reg;
    logic signed [17:0]        contrib_r_reg;
    logic [CW-1:0]             carry_reg;
    logic [rvg_pkg::DIV_W-1:0] rem_reg;
    logic [rvg_pkg::DIV_W-1:0] div_reg;
    logic [rvg_pkg::POS_W-1:0] dvd_reg;
    rvg_pkg::rem_kind_t        kind_reg;
    logic [AW-1:0]             rd_addr_reg;

    // output register
    logic                      m_tvalid_reg;
    logic signed [15:0]        out_l_reg;
    logic signed [15:0]        out_r_reg;
    logic                      out_play_reg;

    // combinational helpers
    logic [rvg_pkg::LEN_W-1:0] len_eff;
    logic [rvg_pkg::POS_W-1:0] len_pos;
    logic                      stereo;
    logic                      ramp_stop;
    logic                      pos_lt_len;
    logic [rvg_pkg::DIV_W:0]   rem_shift;
    logic [rvg_pkg::DIV_W-1:0] rem_next;
    logic                      rem_last;
    logic [rvg_pkg::LEN_W-1:0] f1_inc;
    logic [rvg_pkg::LEN_W-1:0] f2;
    logic [17:0]               word;
    logic [rvg_pkg::POS_W-1:0] word_pos;
    logic                      word_rem;
    logic [rvg_pkg::POS_W-1:0] pos_new;
    logic                      pos_new_lt;
    logic                      out_free;
    logic signed [15:0]        smp_a_cur;
    logic signed [15:0]        smp_b_cur;
    logic [15:0]               gain_cur;
    logic [ACC_W-1:0]          acc;
    logic signed [AL_W-1:0]    shr_frac;
    logic signed [AL_W-1:0]    shr_gain;
    logic [AXW-1:0]            addr_ext;
    logic                      wr_en;

    // shared unit and store connections
    rvg_pkg::alu_op_t          alu_op;
    logic signed [AL_W-1:0]    alu_a;
    logic signed [AL_W-1:0]    alu_b;
    logic signed [AL_W-1:0]    alu_sum;
    logic signed [AL_W-1:0]    alu_prod;
    logic                      rd_en;
    logic signed [15:0]        rd_data;

    // field unpacking
    assign store_address = s_tdata[15:0];
    assign store_value   = s_tdata[31:16];
    assign mix_left      = s_tdata[47:32];
    assign mix_right     = s_tdata[63:48];
    assign action        = s_tuser;

    assign s_tready  = (state_reg == rvg_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // store write straight from the accepted transaction
    assign addr_ext = AXW'(store_address);
    assign wr_en    = in_accept && (action == rvg_pkg::ACT_WRITE)
                      && (rvg_pkg::DIV_W'(store_address) < STORE_LIM);

    // decoded configuration and compares
    assign len_eff    = (length_reg == '0) ? rvg_pkg::LEN_W'(1) : length_reg;
    assign len_pos    = rvg_pkg::POS_W'(len_eff);
    assign stereo     = (chan_reg == 2'd2);
    assign pos_lt_len = pos_reg < len_pos;
    assign ramp_stop  = !pos_lt_len && !loop_reg;

    // remainder step: shift in one dividend bit, subtract divisor if it fits
    assign rem_shift = {rem_reg, dvd_reg[rvg_pkg::POS_W-1]};
    assign rem_next  = alu_sum[AL_W-1] ? rem_shift[rvg_pkg::DIV_W-1:0]
                                       : alu_sum[rvg_pkg::DIV_W-1:0];
    assign rem_last  = (cnt_reg == rvg_pkg::CNT_W'(rvg_pkg::POS_W - 1));

    // right neighbour frame, wraps to frame 0
    assign f1_inc = f1_reg + rvg_pkg::LEN_W'(1);
    assign f2     = (f1_inc == len_eff) ? '0 : f1_inc;

    // word index of the current read
    assign word     = (k_reg[1] ? w2_reg : w1_reg) + 18'(stereo & k_reg[0]);
    assign word_pos = rvg_pkg::POS_W'(word);
    assign word_rem = !STORE_POW2 && (rvg_pkg::DIV_W'(word) >= STORE_LIM);

    // advance results
    assign acc        = alu_sum[ACC_W-1:0];
    assign pos_new    = alu_sum[rvg_pkg::POS_W-1:0];
    assign pos_new_lt = pos_new < len_pos;
    assign shr_frac   = alu_sum >>> FW;
    assign shr_gain   = alu_sum >>> rvg_pkg::GAIN_SHIFT;

    // per-channel operand selection
    assign smp_a_cur = smp_a_reg[ch_reg];
    assign smp_b_cur = smp_b_reg[ch_reg];
    assign gain_cur  = ch_reg ? gain_r_reg : gain_l_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rvg_pkg::ST_IDLE:
            begin
                if (in_accept && (action == rvg_pkg::ACT_PRODUCE))
                begin
                    state_next = active_reg ? rvg_pkg::ST_RAMP : rvg_pkg::ST_FINISH;
                end
            end
            rvg_pkg::ST_RAMP:
            begin
                if (ramp_stop)
                begin
                    state_next = rvg_pkg::ST_FINISH;
                end
                else if (pos_lt_len)
                begin
                    state_next = rvg_pkg::ST_NEXTF;
                end
                else
                begin
                    state_next = rvg_pkg::ST_REM;
                end
            end
            rvg_pkg::ST_REM:
            begin
                if (rem_last)
                begin
                    case (kind_reg)
                        rvg_pkg::REM_POS:  state_next = rvg_pkg::ST_NEXTF;
                        rvg_pkg::REM_WORD: state_next = rvg_pkg::ST_RD;
                        rvg_pkg::REM_ADV:  state_next = rvg_pkg::ST_FINISH;
                        default:           state_next = rvg_pkg::ST_IDLE;
                    endcase
                end
            end
            rvg_pkg::ST_NEXTF: state_next = rvg_pkg::ST_WORD;
            rvg_pkg::ST_WORD:  state_next = word_rem ? rvg_pkg::ST_REM : rvg_pkg::ST_RD;
            rvg_pkg::ST_RD:    state_next = rvg_pkg::ST_CAP;
            rvg_pkg::ST_CAP:   state_next = (k_reg == 2'd3) ? rvg_pkg::ST_ISUB : rvg_pkg::ST_WORD;
            rvg_pkg::ST_ISUB:  state_next = rvg_pkg::ST_IMUL;
            rvg_pkg::ST_IMUL:  state_next = rvg_pkg::ST_IBIAS;
            rvg_pkg::ST_IBIAS: state_next = rvg_pkg::ST_IADD;
            rvg_pkg::ST_IADD:  state_next = rvg_pkg::ST_GMUL;
            rvg_pkg::ST_GMUL:  state_next = rvg_pkg::ST_GBIAS;
            rvg_pkg::ST_GBIAS: state_next = ch_reg ? rvg_pkg::ST_ADV1 : rvg_pkg::ST_ISUB;
            rvg_pkg::ST_ADV1:  state_next = rvg_pkg::ST_ADV2;
            rvg_pkg::ST_ADV2:
            begin
                state_next = (loop_reg && !pos_new_lt) ? rvg_pkg::ST_REM : rvg_pkg::ST_FINISH;
            end
            rvg_pkg::ST_FINISH: state_next = out_free ? rvg_pkg::ST_IDLE : rvg_pkg::ST_FINISH;
            default:            state_next = rvg_pkg::ST_IDLE;
        endcase
    end

    // shared unit operands and store read control
    always_comb
    begin
        alu_op = rvg_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        rd_en  = 1'b0;
        case (state_reg)
            rvg_pkg::ST_REM:
            begin
                alu_op = rvg_pkg::ALU_SUB;
                alu_a  = AL_W'(rem_shift);
                alu_b  = AL_W'(div_reg);
            end
            rvg_pkg::ST_RD:
            begin
                rd_en = 1'b1;
            end
            rvg_pkg::ST_ISUB:
            begin
                alu_op = rvg_pkg::ALU_SUB;
                alu_a  = AL_W'(smp_b_cur);
                alu_b  = AL_W'(smp_a_cur);
            end
            rvg_pkg::ST_IMUL:
            begin
                alu_op = rvg_pkg::ALU_MUL;
                alu_a  = AL_W'(d_reg);
                alu_b  = AL_W'(frac_reg);
            end
            rvg_pkg::ST_IBIAS:
            begin
                alu_a = alu_prod;
                alu_b = alu_prod[AL_W-1] ? FRAC_BIAS : '0;
            end
            rvg_pkg::ST_IADD:
            begin
                alu_a = AL_W'(smp_a_cur);
                alu_b = AL_W'(q_reg);
            end
            rvg_pkg::ST_GMUL:
            begin
                alu_op = rvg_pkg::ALU_MUL;
                alu_a  = AL_W'(v_reg);
                alu_b  = AL_W'(gain_cur);
            end
            rvg_pkg::ST_GBIAS:
            begin
                alu_a = alu_prod;
                alu_b = alu_prod[AL_W-1] ? GAIN_BIAS : '0;
            end
            rvg_pkg::ST_ADV1:
            begin
                alu_a = AL_W'(frac_reg);
                alu_b = AL_W'(pitch_reg);
            end
            rvg_pkg::ST_ADV2:
            begin
                alu_a = AL_W'(pos_reg);
                alu_b = AL_W'(carry_reg);
            end
            default:
            begin
                alu_op = rvg_pkg::ALU_ADD;
            end
        endcase
    end

    // control and voice state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rvg_pkg::ST_IDLE;
            pitch_reg    <= rvg_pkg::PITCH_W'(32768);
            tgt_l_reg    <= '0;
            tgt_r_reg    <= '0;
            gstep_reg    <= 16'd128;
            length_reg   <= rvg_pkg::LEN_W'(1);
            chan_reg     <= 2'd1;
            loop_reg     <= 1'b0;
            start_reg    <= '0;
            pos_reg      <= '0;
            frac_reg     <= '0;
            gain_l_reg   <= '0;
            gain_r_reg   <= '0;
            active_reg   <= 1'b0;
            cnt_reg      <= '0;
            k_reg        <= '0;
            ch_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    rvg_pkg::CFG_PITCH_STEP:    pitch_reg  <= cfg_data[rvg_pkg::PITCH_W-1:0];
                    rvg_pkg::CFG_TARGET_LEFT:   tgt_l_reg  <= cfg_data[15:0];
                    rvg_pkg::CFG_TARGET_RIGHT:  tgt_r_reg  <= cfg_data[15:0];
                    rvg_pkg::CFG_MAX_GAIN_STEP: gstep_reg  <= cfg_data[15:0];
                    rvg_pkg::CFG_LENGTH:        length_reg <= cfg_data[rvg_pkg::LEN_W-1:0];
                    rvg_pkg::CFG_CHANNELS:      chan_reg   <= cfg_data[1:0];
                    rvg_pkg::CFG_LOOP:          loop_reg   <= cfg_data[0];
                    rvg_pkg::CFG_START:         start_reg  <= cfg_data[15:0];
                    default:                    loop_reg   <= loop_reg;
                endcase
            end

            // restart
            if (in_accept && (action == rvg_pkg::ACT_RESTART))
            begin
                pos_reg    <= rvg_pkg::POS_W'(start_reg);
                frac_reg   <= '0;
                gain_l_reg <= '0;
                gain_r_reg <= '0;
                active_reg <= 1'b1;
            end

            // gain ramp and end check
            if (state_reg == rvg_pkg::ST_RAMP)
            begin
                gain_l_reg <= ramp(gain_l_reg, tgt_l_reg, gstep_reg);
                gain_r_reg <= ramp(gain_r_reg, tgt_r_reg, gstep_reg);
                if (ramp_stop)
                begin
                    active_reg <= 1'b0;
                end
            end

            // remainder iteration count
            if (state_next == rvg_pkg::ST_REM && state_reg != rvg_pkg::ST_REM)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == rvg_pkg::ST_REM)
            begin
                cnt_reg <= cnt_reg + rvg_pkg::CNT_W'(1);
            end

            // wrapped position after a loop advance
            if (state_reg == rvg_pkg::ST_REM && rem_last && kind_reg == rvg_pkg::REM_ADV)
            begin
                pos_reg <= rvg_pkg::POS_W'(rem_next);
            end

            // read index and channel index
            if (state_reg == rvg_pkg::ST_NEXTF)
            begin
                k_reg <= '0;
            end
            else if (state_reg == rvg_pkg::ST_CAP)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (state_reg == rvg_pkg::ST_CAP)
            begin
                ch_reg <= 1'b0;
            end
            else if (state_reg == rvg_pkg::ST_GBIAS)
            begin
                ch_reg <= 1'b1;
            end

            // position advance
            if (state_reg == rvg_pkg::ST_ADV1)
            begin
                frac_reg <= acc[FW-1:0];
            end
            if (state_reg == rvg_pkg::ST_ADV2)
            begin
                if (!loop_reg || pos_new_lt)
                begin
                    pos_reg <= pos_new;
                end
                if (!loop_reg)
                begin
                    active_reg <= pos_new_lt;
                end
            end

            // output register valid
            if (state_reg == rvg_pkg::ST_FINISH && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mix_l_reg     <= mix_left;
            mix_r_reg     <= mix_right;
            contrib_l_reg <= '0;
            contrib_r_reg <= '0;
        end

        // remainder setup and steps
        if (state_reg == rvg_pkg::ST_RAMP)
        begin
            f1_reg   <= pos_reg[rvg_pkg::LEN_W-1:0];
            rem_reg  <= '0;
            div_reg  <= rvg_pkg::DIV_W'(len_eff);
            dvd_reg  <= pos_reg;
            kind_reg <= rvg_pkg::REM_POS;
        end
        if (state_reg == rvg_pkg::ST_WORD)
        begin
            rd_addr_reg <= word_pos[AW-1:0];
            rem_reg     <= '0;
            div_reg     <= STORE_LIM;
            dvd_reg     <= word_pos;
            kind_reg    <= rvg_pkg::REM_WORD;
        end
        if (state_reg == rvg_pkg::ST_ADV2)
        begin
            rem_reg  <= '0;
            div_reg  <= rvg_pkg::DIV_W'(len_eff);
            dvd_reg  <= pos_new;
            kind_reg <= rvg_pkg::REM_ADV;
        end
        if (state_reg == rvg_pkg::ST_REM)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[rvg_pkg::POS_W-2:0], 1'b0};
            if (rem_last && kind_reg == rvg_pkg::REM_POS)
            begin
                f1_reg <= rem_next[rvg_pkg::LEN_W-1:0];
            end
            if (rem_last && kind_reg == rvg_pkg::REM_WORD)
            begin
                rd_addr_reg <= rem_next[AW-1:0];
            end
        end

        // word bases of both frames
        if (state_reg == rvg_pkg::ST_NEXTF)
        begin
            w1_reg <= stereo ? {f1_reg, 1'b0} : {1'b0, f1_reg};
            w2_reg <= stereo ? {f2, 1'b0} : {1'b0, f2};
        end

        // capture read samples
        if (state_reg == rvg_pkg::ST_CAP)
        begin
            if (k_reg[1])
            begin
                smp_b_reg[k_reg[0]] <= rd_data;
            end
            else
            begin
                smp_a_reg[k_reg[0]] <= rd_data;
            end
        end

        // interpolation and gain steps
        if (state_reg == rvg_pkg::ST_ISUB)
        begin
            d_reg <= alu_sum[16:0];
        end
        if (state_reg == rvg_pkg::ST_IBIAS)
        begin
            q_reg <= shr_frac[16:0];
        end
        if (state_reg == rvg_pkg::ST_IADD)
        begin
            v_reg <= alu_sum[15:0];
        end
        if (state_reg == rvg_pkg::ST_GBIAS)
        begin
            if (ch_reg)
            begin
                contrib_r_reg <= shr_gain[17:0];
            end
            else
            begin
                contrib_l_reg <= shr_gain[17:0];
            end
        end
        if (state_reg == rvg_pkg::ST_ADV1)
        begin
            carry_reg <= acc[ACC_W-1:FW];
        end

        // result load
        if (state_reg == rvg_pkg::ST_FINISH && out_free)
        begin
            out_l_reg    <= sat_mix(mix_l_reg, contrib_l_reg);
            out_r_reg    <= sat_mix(mix_r_reg, contrib_r_reg);
            out_play_reg <= active_reg;
        end
    end

    // shared arithmetic unit
    rvg_alu #(
        .MUL_B_W (MB)
    ) u_alu (
        .clk    (clk),
        .op     (alu_op),
        .opnd_a (alu_a),
        .opnd_b (alu_b),
        .sum    (alu_sum),
        .prod   (alu_prod)
    );

    // sample store
    rvg_store #(
        .WORDS (STORE_WORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_ext[AW-1:0]),
        .wr_data (store_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // result stream
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_play_reg, out_r_reg, out_l_reg};

    // checks
    `RVG_ASSERT_NOW(a_rem_below_div, state_reg == rvg_pkg::ST_REM, rem_reg < div_reg, "remainder not below divisor")
    `RVG_ASSERT_NOW(a_frame_in_range, state_reg == rvg_pkg::ST_NEXTF, f1_reg < len_eff, "frame index beyond length")
    `RVG_ASSERT_NEXT(a_finish_holds, state_reg == rvg_pkg::ST_FINISH && m_tvalid_reg && !m_tready, state_reg == rvg_pkg::ST_FINISH, "result load overran held output")
    `RVG_ASSERT_NEXT(a_restart_state, in_accept && action == rvg_pkg::ACT_RESTART, active_reg && frac_reg == '0 && gain_l_reg == '0 && gain_r_reg == '0, "restart did not reset voice")
    `RVG_ASSERT_NOW(a_valid_from_finish, $rose(m_tvalid_reg), $past(state_reg == rvg_pkg::ST_FINISH), "output valid without finish step")

endmodule

### tb/sv/tb_resampling_voice_with_gain_ramp_core.sv
// self-checking testbench for the resampling voice core with a built-in voice predictor
`timescale 1ns / 1ps

module tb_resampling_voice_with_gain_ramp_core;
    import rvg_pkg::*;

    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 200;
    localparam int TIMEOUT_NS    = 30_000_000;

    // action code the block ignores, and the channel code that selects stereo
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] CH_STEREO  = 2'd2;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        playing;
    } voice_out_t;

    // one row of the directed table: a register write or an input transaction
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [1:0]           act;
        logic [15:0]          addr;
        logic [15:0]          val;
        logic [15:0]          ml;
        logic [15:0]          mr;
        bit                   has_fixed;
        voice_out_t           fixed_out;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    voice_out_t pending_frames[$];
    dir_row_t   dir_tab[$];

    // predicted voice state
    logic [15:0] smp_mem [0:65535];
    bit          smp_valid [0:65535];
    logic [19:0] voice_pos   = '0;
    logic [14:0] voice_frac  = '0;
    logic [15:0] gain_left   = '0;
    logic [15:0] gain_right  = '0;
    bit          voice_on    = 1'b0;

    // predicted register contents, at their reset values
    logic [17:0] cfg_pitch   = 18'd32768;
    logic [15:0] cfg_tgt_l   = '0;
    logic [15:0] cfg_tgt_r   = '0;
    logic [15:0] cfg_gstep   = 16'd128;
    logic [16:0] cfg_len     = 17'd1;
    logic [1:0]  cfg_chans   = 2'd1;
    logic        cfg_loop    = 1'b0;
    logic [15:0] cfg_start   = '0;

    resampling_voice_with_gain_ramp_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("resampling_voice_with_gain_ramp_core test failed");
        $finish;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------- voice predictor ----------------

    function automatic longint eff_span();
        return (cfg_len == '0) ? 64'sd1 : longint'(cfg_len);
    endfunction

    function automatic longint eff_chans();
        return (cfg_chans == CH_STEREO) ? 64'sd2 : 64'sd1;
    endfunction

    // the next produce on the voice reads the store
    function automatic bit reads_store();
        return voice_on && !(voice_pos >= eff_span() && !cfg_loop);
    endfunction

    function automatic longint stored_word(input longint idx);
        logic [15:0] w;
        w = 16'(idx);
        return longint'($signed(smp_mem[w]));
    endfunction

    // linear interpolation, product truncated toward zero
    function automatic longint lerp(input longint a, input longint b, input longint f);
        return a + ((b - a) * f) / 32768;
    endfunction

    function automatic logic [15:0] sat16(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    function automatic logic [15:0] ramp_gain(input logic [15:0] cur, input logic [15:0] tgt);
        if (tgt > cur)
            return (tgt - cur > cfg_gstep) ? cur + cfg_gstep : tgt;
        return (cur - tgt > cfg_gstep) ? cur - cfg_gstep : tgt;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] v);
        case (idx)
            CFG_PITCH_STEP:    cfg_pitch = v[17:0];
            CFG_TARGET_LEFT:   cfg_tgt_l = v[15:0];
            CFG_TARGET_RIGHT:  cfg_tgt_r = v[15:0];
            CFG_MAX_GAIN_STEP: cfg_gstep = v[15:0];
            CFG_LENGTH:        cfg_len   = v[16:0];
            CFG_CHANNELS:      cfg_chans = v[1:0];
            CFG_LOOP:          cfg_loop  = v[0];
            CFG_START:         cfg_start = v[15:0];
            default:           ;
        endcase
    endfunction

    // applies one input transaction to the voice; returns 1 with the mixed frame for a produce
    function automatic bit advance_voice(input logic [1:0] act, input logic [15:0] addr,
                                         input logic [15:0] val, input logic [15:0] ml,
                                         input logic [15:0] mr, output voice_out_t frame);
        longint span, chans, f1, f2, w1, w2, vl, vr, cl, cr, acc, npos, g;
        frame = '0;
        cl = 0;
        cr = 0;
        case (act)
            ACT_WRITE:
            begin
                smp_mem[addr]   = val;
                smp_valid[addr] = 1'b1;
                return 1'b0;
            end
            ACT_RESTART:
            begin
                voice_pos  = 20'(cfg_start);
                voice_frac = '0;
                gain_left  = '0;
                gain_right = '0;
                voice_on   = 1'b1;
                return 1'b0;
            end
            ACT_PRODUCE: ;
            default:
                return 1'b0;
        endcase

        if (voice_on)
        begin
            span       = eff_span();
            chans      = eff_chans();
            gain_left  = ramp_gain(gain_left, cfg_tgt_l);
            gain_right = ramp_gain(gain_right, cfg_tgt_r);
            npos       = voice_pos;
            // past the end without looping: silent and stopped, position held
            if (npos >= span && !cfg_loop)
                voice_on = 1'b0;
            else
            begin
                f1 = npos % span;
                f2 = (f1 + 1) % span;
                w1 = f1 * chans;
                w2 = f2 * chans;
                vl = lerp(stored_word(w1), stored_word(w2), longint'(voice_frac));
                vr = lerp(stored_word(w1 + chans - 1), stored_word(w2 + chans - 1),
                          longint'(voice_frac));
                g  = gain_left;
                cl = (vl * g) / 32768;
                g  = gain_right;
                cr = (vr * g) / 32768;
                // advance in Q15, position kept to 20 bits
                acc        = longint'(voice_frac) + longint'(cfg_pitch);
                npos       = (npos + (acc >> 15)) & 64'hFFFFF;
                voice_frac = 15'(acc);
                if (cfg_loop)
                    npos = npos % span;
                else
                    voice_on = (npos < span);
                voice_pos = 20'(npos);
            end
        end
        frame.left    = sat16(longint'($signed(ml)) + cl);
        frame.right   = sat16(longint'($signed(mr)) + cr);
        frame.playing = voice_on;
        return 1'b1;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [15:0] rand_mix();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic dir_row_t item_row(input logic [1:0] act, input logic [15:0] addr,
                                          input logic [15:0] val, input logic [15:0] ml,
                                          input logic [15:0] mr);
        dir_row_t r;
        r = '{default: '0};
        r.act  = act;
        r.addr = addr;
        r.val  = val;
        r.ml   = ml;
        r.mr   = mr;
        return r;
    endfunction

    // produce row whose result is obvious: stopped voice passes the mix through
    function automatic dir_row_t fixed_row(input logic [15:0] ml, input logic [15:0] mr,
                                           input logic [15:0] el, input logic [15:0] er,
                                           input logic ep);
        dir_row_t r;
        r = item_row(ACT_PRODUCE, '0, '0, ml, mr);
        r.has_fixed = 1'b1;
        r.fixed_out = '{left: el, right: er, playing: ep};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] v);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        return r;
    endfunction

    // one input transaction, with random sender gaps; prediction at acceptance
    task automatic send_item(input logic [1:0] act, input logic [15:0] addr,
                             input logic [15:0] val, input logic [15:0] ml,
                             input logic [15:0] mr, input bit use_fixed,
                             input voice_out_t fixed_out);
        int         gap;
        voice_out_t frame;
        @(negedge clk);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {mr, ml, val, addr};
        do
            @(posedge clk);
        while (!s_tready);
        if (advance_voice(act, addr, val, ml, mr, frame))
            pending_frames.push_back(use_fixed ? fixed_out : frame);
    endtask

    // writes any store word the next produce would read before it was ever written
    task automatic prime_store();
        longint      f1, f2, chans;
        logic [15:0] words [4];
        if (!reads_store())
            return;
        chans    = eff_chans();
        f1       = voice_pos % eff_span();
        f2       = (f1 + 1) % eff_span();
        words[0] = 16'(f1 * chans);
        words[1] = 16'(f2 * chans);
        words[2] = 16'(f1 * chans + chans - 1);
        words[3] = 16'(f2 * chans + chans - 1);
        foreach (words[k])
            if (!smp_valid[words[k]])
                send_item(ACT_WRITE, words[k], 16'($urandom), rand_mix(), rand_mix(),
                          1'b0, '0);
    endtask

    // stop sending, wait for every expected frame, then let the block go quiet
    task automatic settle_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        apply_reg(idx, v);
    endtask

    // full register set: a few fixed corner settings, otherwise mostly small random ones
    task automatic load_setting(input int phase_no);
        logic [17:0] pitch;
        logic [15:0] tl, tr, gs, st;
        logic [16:0] ln;
        logic [1:0]  ch;
        logic        lp;
        case (phase_no % 6)
            0:
            begin
                pitch = 18'h3FFFF; tl = 16'hFFFF; tr = 16'hFFFF; gs = 16'hFFFF;
                ln = 17'h1FFFF; ch = 2'd3; lp = 1'b1; st = 16'hFFFF;
            end
            1:
            begin
                pitch = '0; tl = '0; tr = '0; gs = '0;
                ln = '0; ch = 2'd0; lp = 1'b0; st = '0;
            end
            2:
            begin
                pitch = 18'h3FFFF; tl = 16'd32768; tr = 16'd32768; gs = 16'd1;
                ln = 17'd65536; ch = CH_STEREO; lp = 1'b1; st = 16'hFFFF;
            end
            default:
            begin
                pitch = ($urandom_range(3) == 0) ? 18'($urandom_range(0, 262143))
                                                 : 18'($urandom_range(0, 65536));
                tl = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
                tr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
                gs = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
                ln = ($urandom_range(7) == 0) ? 17'($urandom_range(0, 131071))
                                              : 17'($urandom_range(0, 8));
                ch = 2'($urandom_range(0, 3));
                lp = 1'($urandom_range(0, 1));
                st = ($urandom_range(7) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 32'(ln) + 1));
            end
        endcase
        write_reg(CFG_PITCH_STEP, CFG_W'(pitch));
        write_reg(CFG_TARGET_LEFT, CFG_W'(tl));
        write_reg(CFG_TARGET_RIGHT, CFG_W'(tr));
        write_reg(CFG_MAX_GAIN_STEP, CFG_W'(gs));
        write_reg(CFG_LENGTH, CFG_W'(ln));
        write_reg(CFG_CHANNELS, CFG_W'(ch));
        write_reg(CFG_LOOP, CFG_W'(lp));
        write_reg(CFG_START, CFG_W'(st));
    endtask

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin : check_results
        voice_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t unexpected result transaction: expected none got %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_frames.pop_front();
                if (m_tdata[15:0] !== want.left)
                begin
                    $display("%0t out_left mismatch: expected %0d got %0d", $time,
                             $signed(want.left), $signed(m_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_tdata[31:16] !== want.right)
                begin
                    $display("%0t out_right mismatch: expected %0d got %0d", $time,
                             $signed(want.right), $signed(m_tdata[31:16]));
                    mismatch_count++;
                end
                if (m_tdata[32] !== want.playing)
                begin
                    $display("%0t is_playing mismatch: expected %0d got %0d", $time,
                             want.playing, m_tdata[32]);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    initial
    begin : stimulus
        int         phase_no;
        int         phase_len;
        int         counted;
        int         random_items;
        int         pick;
        logic [15:0] wr_addr;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // stopped voice after reset, unknown action, store extremes
        dir_tab.push_back(fixed_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        dir_tab.push_back(fixed_row(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0));
        dir_tab.push_back(item_row(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        dir_tab.push_back(item_row(ACT_WRITE, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000));
        dir_tab.push_back(item_row(ACT_WRITE, 16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF));
        dir_tab.push_back(item_row(ACT_WRITE, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000));
        dir_tab.push_back(item_row(ACT_WRITE, 16'hFFFE, 16'h7FFF, 16'h0000, 16'h0000));
        // unity gain left, gain above one right, instant ramp, half-frame steps
        dir_tab.push_back(cfg_row(CFG_TARGET_LEFT, 18'd32768));
        dir_tab.push_back(cfg_row(CFG_TARGET_RIGHT, 18'd65535));
        dir_tab.push_back(cfg_row(CFG_MAX_GAIN_STEP, 18'd65535));
        dir_tab.push_back(cfg_row(CFG_PITCH_STEP, 18'd16384));
        dir_tab.push_back(cfg_row(CFG_LENGTH, 18'd2));
        // mono play to the end: wrap to frame 0 on the last frame, then stop
        dir_tab.push_back(item_row(ACT_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        dir_tab.push_back(item_row(ACT_PRODUCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        dir_tab.push_back(item_row(ACT_PRODUCE, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000));
        dir_tab.push_back(item_row(ACT_PRODUCE, 16'h0000, 16'h0000, 16'h8000, 16'h8000));
        dir_tab.push_back(item_row(ACT_PRODUCE, 16'h0000, 16'h0000, 16'h1234, 16'hEDCB));
        // restart beyond the length without looping: silent, stopped at once
        dir_tab.push_back(cfg_row(CFG_START, 18'd65535));
        dir_tab.push_back(item_row(ACT_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        dir_tab.push_back(fixed_row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
        // stereo on the last frame of a full store: word index wraps, loop wraps position
        dir_tab.push_back(cfg_row(CFG_CHANNELS, 18'd2));
        dir_tab.push_back(cfg_row(CFG_LENGTH, 18'd65536));
        dir_tab.push_back(cfg_row(CFG_LOOP, 18'd1));
        dir_tab.push_back(item_row(ACT_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        dir_tab.push_back(item_row(ACT_PRODUCE, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF));
        dir_tab.push_back(item_row(ACT_PRODUCE, 16'h0000, 16'h0000, 16'h8000, 16'h8000));

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                settle_idle();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end
            else
            begin
                if (dir_tab[i].act == ACT_PRODUCE)
                    prime_store();
                send_item(dir_tab[i].act, dir_tab[i].addr, dir_tab[i].val, dir_tab[i].ml,
                          dir_tab[i].mr, dir_tab[i].has_fixed, dir_tab[i].fixed_out);
            end
        end

        // random phases, each with its own register set and idle pattern
        phase_no     = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle_idle();
            load_setting(phase_no);
            case (phase_no % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            send_item(ACT_RESTART, 16'($urandom), 16'($urandom), rand_mix(), rand_mix(),
                      1'b0, '0);
            phase_len = $urandom_range(40, 80);
            counted   = 0;
            while (counted < phase_len)
            begin
                pick = $urandom_range(99);
                if (pick < 68)
                begin
                    prime_store();
                    send_item(ACT_PRODUCE, 16'($urandom), 16'($urandom), rand_mix(),
                              rand_mix(), 1'b0, '0);
                    counted++;
                end
                else if (pick < 84)
                begin
                    // half the writes land on words the voice is playing
                    wr_addr = ($urandom_range(1) == 1)
                              ? 16'($urandom_range(0, 32'(2 * eff_span() + 1)))
                              : 16'($urandom);
                    send_item(ACT_WRITE, wr_addr, rand_mix(), rand_mix(), rand_mix(),
                              1'b0, '0);
                    counted++;
                end
                else if (pick < 93)
                begin
                    send_item(ACT_RESTART, 16'($urandom), 16'($urandom), rand_mix(),
                              rand_mix(), 1'b0, '0);
                    counted++;
                end
                else
                    send_item(ACT_UNUSED, 16'($urandom), 16'($urandom), rand_mix(),
                              rand_mix(), 1'b0, '0);
            end
            random_items += counted;
            phase_no++;
        end

        settle_idle();
        if (mismatch_count == 0)
            $display("resampling_voice_with_gain_ramp_core test passed");
        else
            $display("resampling_voice_with_gain_ramp_core test failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/rvg_pkg.sv
hdl/rvg_alu.sv
hdl/rvg_store.sv
hdl/resampling_voice_with_gain_ramp_core.sv
tb/sv/tb_resampling_voice_with_gain_ramp_core.sv
